FILE: hw/rtl/stms_pkg.sv
`default_nettype none

package stms_pkg;

  localparam int unsigned NSLOT = 12;
  localparam int unsigned SLOT_W = 4;

  typedef logic [SLOT_W-1:0] slot_t;

  // fixed emit order of one request, lowest index first
  localparam slot_t SLOT_CLOSE_STRIKE = 4'd0;
  localparam slot_t SLOT_CLOSE_ITALIC = 4'd1;
  localparam slot_t SLOT_CLOSE_BOLD   = 4'd2;
  localparam slot_t SLOT_OPEN_BOLD    = 4'd3;
  localparam slot_t SLOT_OPEN_ITALIC  = 4'd4;
  localparam slot_t SLOT_OPEN_STRIKE  = 4'd5;
  localparam slot_t SLOT_ESCAPE       = 4'd6;
  localparam slot_t SLOT_CHAR         = 4'd7;
  localparam slot_t SLOT_END_STRIKE   = 4'd8;
  localparam slot_t SLOT_END_ITALIC   = 4'd9;
  localparam slot_t SLOT_END_BOLD     = 4'd10;
  localparam slot_t SLOT_END_MARK     = 4'd11;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int unsigned STY_BOLD   = 0;
  localparam int unsigned STY_ITALIC = 1;
  localparam int unsigned STY_STRIKE = 2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic ld_nonempty;
    logic pend_one;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] slot_byte(input slot_t slot, input logic [7:0] ch);
    logic [7:0] b;
    b = 8'h00;
    case (slot)
      SLOT_CLOSE_STRIKE, SLOT_OPEN_STRIKE, SLOT_END_STRIKE: b = CH_TILDE;
      SLOT_CLOSE_ITALIC, SLOT_OPEN_ITALIC, SLOT_END_ITALIC: b = CH_UNDER;
      SLOT_CLOSE_BOLD, SLOT_OPEN_BOLD, SLOT_END_BOLD:       b = CH_STAR;
      SLOT_ESCAPE: b = CH_BSLASH;
      SLOT_CHAR:   b = ch;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/styled_text_markdown_serializer.sv
// first byte of a request: loaded into the pending mask, then popped to output register
// a request yields 0 to 8 bytes; the next is accepted only once all are popped
// the pop sequencer moves one byte per cycle into the output register while it is free
// a request that yields no byte and does not end the text is taken without leaving idle
// reset: synchronous active-low rst_n clears open styles, pending bytes and output valid
`default_nettype none

module styled_text_markdown_serializer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_has_char,
  input  wire logic [2:0] in_style,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_text_done
);

  stms_pkg::cmd_t cmd;
  stms_pkg::sts_t sts;

  stms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stms_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char_in     (in_char_in),
    .in_has_char    (in_has_char),
    .in_style       (in_style),
    .in_end_of_text (in_end_of_text),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_text_done  (out_text_done)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/stms_ctrl.sv
`default_nettype none

module stms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire stms_pkg::sts_t sts,
  output stms_pkg::cmd_t      cmd
);

  stms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stms_pkg::ST_IDLE: begin
        if (in_valid && sts.ld_nonempty) state_nxt = stms_pkg::ST_RUN;
      end
      stms_pkg::ST_RUN: begin
        if (sts.out_free && sts.pend_one) state_nxt = stms_pkg::ST_IDLE;
      end
      default: state_nxt = stms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      stms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      stms_pkg::ST_RUN: begin
        cmd.pop = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stms_dp.sv
`default_nettype none

module stms_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     in_char_in,
  input  wire logic           in_has_char,
  input  wire logic [2:0]     in_style,
  input  wire logic           in_end_of_text,
  input  wire stms_pkg::cmd_t cmd,
  output stms_pkg::sts_t      sts,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_text_done
);

  localparam int unsigned N = stms_pkg::NSLOT;

  logic [N-1:0] mask_r, mask_nxt;
  logic [N-1:0] ld_mask;
  logic [N-1:0] low_bit;
  logic [N-1:0] rest;
  logic [2:0]   open_r;
  logic [7:0]   char_r;
  logic         eot_r;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r;
  logic         byte_valid_r;
  logic         text_done_r;
  stms_pkg::slot_t sel;
  logic         markup;

  assign markup = (in_char_in == stms_pkg::CH_STAR) || (in_char_in == stms_pkg::CH_UNDER) ||
                  (in_char_in == stms_pkg::CH_TILDE) || (in_char_in == stms_pkg::CH_BSLASH);

  // one bit per possible byte or end mark of the incoming request
  always_comb begin
    ld_mask = '0;
    ld_mask[stms_pkg::SLOT_CLOSE_STRIKE] = open_r[stms_pkg::STY_STRIKE] &
                                           ~in_style[stms_pkg::STY_STRIKE];
    ld_mask[stms_pkg::SLOT_CLOSE_ITALIC] = open_r[stms_pkg::STY_ITALIC] &
                                           ~in_style[stms_pkg::STY_ITALIC];
    ld_mask[stms_pkg::SLOT_CLOSE_BOLD]   = open_r[stms_pkg::STY_BOLD] &
                                           ~in_style[stms_pkg::STY_BOLD];
    ld_mask[stms_pkg::SLOT_OPEN_BOLD]    = ~open_r[stms_pkg::STY_BOLD] &
                                           in_style[stms_pkg::STY_BOLD];
    ld_mask[stms_pkg::SLOT_OPEN_ITALIC]  = ~open_r[stms_pkg::STY_ITALIC] &
                                           in_style[stms_pkg::STY_ITALIC];
    ld_mask[stms_pkg::SLOT_OPEN_STRIKE]  = ~open_r[stms_pkg::STY_STRIKE] &
                                           in_style[stms_pkg::STY_STRIKE];
    ld_mask[stms_pkg::SLOT_ESCAPE]       = in_has_char & markup;
    ld_mask[stms_pkg::SLOT_CHAR]         = in_has_char;
    ld_mask[stms_pkg::SLOT_END_STRIKE]   = in_end_of_text & in_style[stms_pkg::STY_STRIKE];
    ld_mask[stms_pkg::SLOT_END_ITALIC]   = in_end_of_text & in_style[stms_pkg::STY_ITALIC];
    ld_mask[stms_pkg::SLOT_END_BOLD]     = in_end_of_text & in_style[stms_pkg::STY_BOLD];
    // empty final request still reports the end
    ld_mask[stms_pkg::SLOT_END_MARK]     = in_end_of_text &
                                           (ld_mask[stms_pkg::SLOT_END_MARK-1:0] == '0);
  end

  always_comb begin
    sel = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = stms_pkg::slot_t'(i);
    end
  end

  assign low_bit = mask_r & (~mask_r + {{(N-1){1'b0}}, 1'b1});
  assign rest    = mask_r & ~low_bit;

  always_comb begin
    mask_nxt = mask_r;
    if (cmd.load) begin
      mask_nxt = ld_mask;
    end else if (cmd.pop) begin
      mask_nxt = rest;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      open_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) open_r <= in_end_of_text ? 3'b000 : in_style;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_in;
      eot_r  <= in_end_of_text;
    end
    if (cmd.pop) begin
      out_byte_r   <= stms_pkg::slot_byte(sel, char_r);
      byte_valid_r <= (sel != stms_pkg::SLOT_END_MARK);
      text_done_r  <= eot_r && (rest == '0);
    end
  end

  assign sts.ld_nonempty = (ld_mask != '0);
  assign sts.pend_one    = (rest == '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = byte_valid_r;
  assign out_text_done  = text_done_r;

`ifndef SYNTH
  a_pop_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (mask_r != '0))
    else $error("pop with no pending byte");

  a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (mask_r == '0))
    else $error("new request loaded before previous one drained");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !byte_valid_r) |-> text_done_r)
    else $error("result without byte that is not the end mark");

  a_end_clears_style: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && eot_r && (rest == '0)) |-> (open_r == 3'b000))
    else $error("style still open at end of text");
`endif

endmodule

`default_nettype wire
